// File: hdl/antialiased_line_stepper_macros.svh
// ----------------------------------------------------------------------------
// antialiased_line_stepper_macros
// assertion macros shared by the line stepper, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_STEPPER_MACROS_SVH
`define ANTIALIASED_LINE_STEPPER_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define AALS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AALS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define AALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/aals_pkg.sv
// ----------------------------------------------------------------------------
// aals_pkg
// shared types and constants of the antialiased line stepper
// ----------------------------------------------------------------------------
package aals_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [7:0] ENDPOINT_WEIGHT = 8'd127;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch raw endpoints
        logic swap;        // steep test and axis swap
        logic order;       // endpoint order, dx and magnitude
        logic div_step;    // one quotient bit
        logic div_first;   // first quotient bit, no shift
        logic slope_set;   // signed slope from quotient
        logic emit_first;  // first endpoint column
        logic emit_run;    // interior column
        logic emit_last;   // second endpoint column
    } aals_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more;        // an interior column follows the current one
    } aals_status_t;

endpackage

// File: hdl/aals_ctrl.sv
// ----------------------------------------------------------------------------
// aals_ctrl
// sequencer for line setup, slope division and column stepping
// ----------------------------------------------------------------------------
module aals_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  op,
    input  logic                  m_tready,
    output logic                  s_tready,
    output logic                  m_tvalid,
    output aals_pkg::aals_cmd_t   cmd,
    input  aals_pkg::aals_status_t status
);
    import aals_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    localparam logic [2:0] ST_READY = 3'd0;
    localparam logic [2:0] ST_SWAP  = 3'd1;
    localparam logic [2:0] ST_ORDER = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SLOPE = 3'd4;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_LAST  = 2'd3;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;
    logic          emit;

    assign s_tready = (state_reg == ST_READY) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign emit     = cmd.emit_first || cmd.emit_run || cmd.emit_last;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_READY:
            begin
                if (accept && op == OP_START)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SWAP;
                end
                else if (accept)
                begin
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            cmd.emit_first = 1'b1;
                            phase_next     = status.more ? PH_RUN : PH_LAST;
                        end
                        PH_RUN:
                        begin
                            cmd.emit_run = 1'b1;
                            phase_next   = status.more ? PH_RUN : PH_LAST;
                        end
                        PH_LAST:
                        begin
                            cmd.emit_last = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                cmd.order  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FRAC_BITS))
                begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE:
            begin
                cmd.slope_set = 1'b1;
                phase_next    = PH_FIRST;
                state_next    = ST_READY;
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/aals_datapath.sv
// ----------------------------------------------------------------------------
// aals_datapath
// endpoint setup, restoring slope divider, minor accumulator and output stage
// ----------------------------------------------------------------------------
module aals_datapath #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aals_pkg::aals_cmd_t    cmd,
    output aals_pkg::aals_status_t status,
    input  logic [COORD_BITS-1:0]  start_x,
    input  logic [COORD_BITS-1:0]  start_y,
    input  logic [COORD_BITS-1:0]  end_x,
    input  logic [COORD_BITS-1:0]  end_y,
    output logic [COORD_BITS-1:0]  pix_x,
    output logic [COORD_BITS-1:0]  pix_y,
    output logic [7:0]             base_weight,
    output logic [7:0]             neighbour_weight,
    output logic                   neighbour_on_x,
    output logic                   last
);
    import aals_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SL  = F + 2;
    localparam int ACC = C + F + 1;

    logic           steep_reg, steep_next;
    logic [C-1:0]   major_pos_reg, major_pos_next;
    logic [C-1:0]   major_end_reg, major_end_next;
    logic [C-1:0]   minor_start_reg, minor_start_next;
    logic [C-1:0]   minor_end_reg, minor_end_next;
    logic [ACC-1:0] accum_reg, accum_next;
    logic [SL-1:0]  slope_reg, slope_next;
    logic [C-1:0]   dx_reg, dx_next;
    logic [C:0]     rem_reg, rem_next;
    logic [F:0]     quot_reg, quot_next;
    logic           neg_reg, neg_next;
    logic           dx_zero_reg, dx_zero_next;

    logic [C-1:0]   adx, ady;
    logic           major_swap;
    logic [C:0]     trial;
    logic           trial_ge;
    logic [ACC-1:0] slope_ext;
    logic [C:0]     pos_inc;
    logic [F-1:0]   frac;
    logic [F:0]     frac_inv;
    logic [F+8:0]   base_prod, nb_prod;
    logic [C-1:0]   emit_major, emit_minor;
    logic [7:0]     emit_wb, emit_wn;

    logic [C-1:0]   pix_x_reg, pix_x_next;
    logic [C-1:0]   pix_y_reg, pix_y_next;
    logic [7:0]     wb_reg, wb_next;
    logic [7:0]     wn_reg, wn_next;
    logic           on_x_reg, on_x_next;
    logic           last_reg, last_next;

    assign adx = (major_end_reg > major_pos_reg) ? major_end_reg - major_pos_reg
                                                 : major_pos_reg - major_end_reg;
    assign ady = (minor_end_reg > minor_start_reg) ? minor_end_reg - minor_start_reg
                                                   : minor_start_reg - minor_end_reg;
    assign major_swap = major_pos_reg > major_end_reg;

    assign trial    = cmd.div_first ? rem_reg : {rem_reg[C-1:0], 1'b0};
    assign trial_ge = trial >= {1'b0, dx_reg};

    assign slope_ext = {{(ACC - SL){slope_reg[SL-1]}}, slope_reg};
    assign pos_inc   = {1'b0, major_pos_reg} + 1'b1;
    assign status.more = pos_inc < {1'b0, major_end_reg};

    assign frac      = accum_reg[F-1:0];
    assign frac_inv  = {1'b1, {F{1'b0}}} - {1'b0, frac};
    assign base_prod = {frac_inv, 8'd0} - {8'd0, frac_inv};
    assign nb_prod   = {1'b0, frac, 8'd0} - {9'd0, frac};

    always_comb
    begin
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_start_next = minor_start_reg;
        minor_end_next   = minor_end_reg;
        accum_next       = accum_reg;
        slope_next       = slope_reg;
        dx_next          = dx_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        neg_next         = neg_reg;
        dx_zero_next     = dx_zero_reg;

        if (cmd.load)
        begin
            major_pos_next   = start_x;
            minor_start_next = start_y;
            major_end_next   = end_x;
            minor_end_next   = end_y;
        end

        if (cmd.swap)
        begin
            steep_next = ady > adx;
            if (ady > adx)
            begin
                major_pos_next   = minor_start_reg;
                minor_start_next = major_pos_reg;
                major_end_next   = minor_end_reg;
                minor_end_next   = major_end_reg;
            end
        end

        if (cmd.order)
        begin
            dx_next      = adx;
            dx_zero_next = (adx == '0);
            rem_next     = {1'b0, ady};
            neg_next     = major_swap ? (minor_start_reg < minor_end_reg)
                                      : (minor_end_reg < minor_start_reg);
            if (major_swap)
            begin
                major_pos_next   = major_end_reg;
                major_end_next   = major_pos_reg;
                minor_start_next = minor_end_reg;
                minor_end_next   = minor_start_reg;
            end
        end

        if (cmd.div_step)
        begin
            rem_next  = trial_ge ? trial - {1'b0, dx_reg} : trial;
            quot_next = {quot_reg[F-1:0], trial_ge};
        end

        if (cmd.slope_set)
        begin
            if (dx_zero_reg)
            begin
                slope_next = SL'(1) << F;
            end
            else if (neg_reg)
            begin
                slope_next = '0 - {1'b0, quot_reg};
            end
            else
            begin
                slope_next = {1'b0, quot_reg};
            end
            accum_next = '0;
        end

        if (cmd.emit_first)
        begin
            accum_next     = {1'b0, minor_start_reg, {F{1'b0}}} + slope_ext;
            major_pos_next = pos_inc[C-1:0];
        end

        if (cmd.emit_run)
        begin
            accum_next     = accum_reg + slope_ext;
            major_pos_next = pos_inc[C-1:0];
        end
    end

    // column selection for the output stage
    always_comb
    begin
        emit_major = major_pos_reg;
        emit_minor = minor_start_reg;
        emit_wb    = ENDPOINT_WEIGHT;
        emit_wn    = '0;
        if (cmd.emit_run)
        begin
            emit_minor = accum_reg[F+C-1:F];
            emit_wb    = base_prod[F+7:F];
            emit_wn    = nb_prod[F+7:F];
        end
        else if (cmd.emit_last)
        begin
            emit_major = major_end_reg;
            emit_minor = minor_end_reg;
        end
    end

    always_comb
    begin
        pix_x_next = pix_x_reg;
        pix_y_next = pix_y_reg;
        wb_next    = wb_reg;
        wn_next    = wn_reg;
        on_x_next  = on_x_reg;
        last_next  = last_reg;
        if (cmd.emit_first || cmd.emit_run || cmd.emit_last)
        begin
            pix_x_next = steep_reg ? emit_minor : emit_major;
            pix_y_next = steep_reg ? emit_major : emit_minor;
            wb_next    = emit_wb;
            wn_next    = emit_wn;
            on_x_next  = steep_reg;
            last_next  = cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_start_reg <= '0;
            minor_end_reg   <= '0;
            accum_reg       <= '0;
            slope_reg       <= '0;
        end
        else
        begin
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_start_reg <= minor_start_next;
            minor_end_reg   <= minor_end_next;
            accum_reg       <= accum_next;
            slope_reg       <= slope_next;
        end
    end

    // divider and output payload
    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        neg_reg     <= neg_next;
        dx_zero_reg <= dx_zero_next;
        pix_x_reg   <= pix_x_next;
        pix_y_reg   <= pix_y_next;
        wb_reg      <= wb_next;
        wn_reg      <= wn_next;
        on_x_reg    <= on_x_next;
        last_reg    <= last_next;
    end

    assign pix_x            = pix_x_reg;
    assign pix_y            = pix_y_reg;
    assign base_weight      = wb_reg;
    assign neighbour_weight = wn_reg;
    assign neighbour_on_x   = on_x_reg;
    assign last             = last_reg;

endmodule

// File: hdl/antialiased_line_stepper.sv
// ----------------------------------------------------------------------------
// antialiased_line_stepper
// Wu antialiased line stepper, one pixel column per step request
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes requests; s_tuser is the operation (0 start, 1 step),
//   s_tdata carries the endpoints, used on start only.
//   a start request yields no result; the block then sets up the line and
//   divides for the gradient one quotient bit per cycle, and takes no new
//   request until the slope is set.
//   each step request yields one column on the m_* channel in the next cycle:
//   first endpoint, interior columns, second endpoint with m_tlast high.
//   steps arrive at one per cycle while the receiver keeps m_tready high.
//   a step with no line in progress is dropped without a result.
//   the result sits in an output register; while the receiver stalls it
//   holds, and s_tready stays low until the register frees up.
//   reset returns to no line in progress with no result pending.
// ----------------------------------------------------------------------------
`include "antialiased_line_stepper_macros.svh"

module antialiased_line_stepper #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // start_x, start_y, end_x, end_y, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    // operation
    input  logic                                      s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // pix_x, pix_y, base_weight, neighbour_weight, zero fill
    output logic [((2*COORD_BITS+16+7)/8)*8-1:0]      m_tdata,
    // neighbour_on_x
    output logic                                      m_tuser,
    output logic                                      m_tlast
);
    import aals_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((2*COORD_BITS+16+7)/8)*8;
    localparam int FILL_W = OUT_W - (2*C + 16);

    aals_cmd_t    cmd;
    aals_status_t status;

    logic [C-1:0] pix_x, pix_y;
    logic [7:0]   base_weight, neighbour_weight;

    aals_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .status   (status)
    );

    aals_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .start_x          (s_tdata[C-1:0]),
        .start_y          (s_tdata[2*C-1:C]),
        .end_x            (s_tdata[3*C-1:2*C]),
        .end_y            (s_tdata[4*C-1:3*C]),
        .pix_x            (pix_x),
        .pix_y            (pix_y),
        .base_weight      (base_weight),
        .neighbour_weight (neighbour_weight),
        .neighbour_on_x   (m_tuser),
        .last             (m_tlast)
    );

    assign m_tdata = {{FILL_W{1'b0}}, neighbour_weight, base_weight, pix_y, pix_x};

    // a request is only taken when the output register can receive a result
    `AALS_ASSERT_SAME(a_room_on_accept, clk, rst_n, s_tvalid && s_tready, !m_tvalid || m_tready, "request taken with output blocked")

    // a start keeps the block busy for the setup that follows
    `AALS_ASSERT_NEXT(a_busy_after_start, clk, rst_n, s_tvalid && s_tready && s_tuser == OP_START, !s_tready, "ready right after start")

    // a column is produced only for a step request taken this cycle
    `AALS_ASSERT_SAME(a_emit_on_step, clk, rst_n, cmd.emit_first || cmd.emit_run || cmd.emit_last, s_tvalid && s_tready && s_tuser == OP_STEP, "column without step request")

    // setup commands never overlap a column
    `AALS_ASSERT_SAME(a_setup_exclusive, clk, rst_n, cmd.div_step || cmd.slope_set || cmd.swap || cmd.order, !s_tready, "setup while ready")

endmodule
